### design/mipq_pkg.sv
// ----------------------------------------------------------------------------
// mipq_pkg: shared types and constants for the min-id process queue
// Record, request and result layouts, status codes and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package mipq_pkg;

    // Queue sizing
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request modes
    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_EXTRACTED = 2'd3;

    // Input request payload
    typedef struct packed {
        logic        mode;
        logic [15:0] process_id;
        logic [31:0] arrival_time;
        logic [31:0] service_time;
    } mipq_in_t;

    // Result payload
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [31:0] out_arrival;
        logic [31:0] out_service;
        logic [4:0]  occupancy;
    } mipq_out_t;

    // One stored process record
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [31:0] service;
    } mipq_rec_t;

    // Broadcast control to every cell
    typedef struct packed {
        logic      insert;
        logic      extract;
        mipq_rec_t rec;
    } mipq_ctrl_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic      valid;
        logic      le;      // holds a record that the new one goes after
        mipq_rec_t rec;
    } mipq_link_t;

endpackage

`default_nettype wire

### design/mipq_cell.sv
// ----------------------------------------------------------------------------
// mipq_cell: one slot of the sorted shift-register queue
// Holds one record; on insert it keeps, takes the new record or takes its
// left neighbor; on extract it takes its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mipq_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mipq_pkg::mipq_ctrl_t ctrl,
    input  wire mipq_pkg::mipq_link_t left_link,
    input  wire mipq_pkg::mipq_link_t right_link,
    output mipq_pkg::mipq_link_t      own_link
);

    logic                valid_reg;
    logic                valid_next;
    mipq_pkg::mipq_rec_t rec_reg;
    mipq_pkg::mipq_rec_t rec_next;
    logic                le;

    // New record sorts after this one (ties: older stays ahead)
    assign le = valid_reg && (rec_reg.id <= ctrl.rec.id);

    assign own_link.valid = valid_reg;
    assign own_link.le    = le;
    assign own_link.rec   = rec_reg;

    // Next-state selection
    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctrl.extract) begin
            valid_next = right_link.valid;
            rec_next   = right_link.rec;
        end else if (ctrl.insert && !le) begin
            if (left_link.le) begin
                valid_next = 1'b1;
                rec_next   = ctrl.rec;
            end else begin
                valid_next = left_link.valid;
                rec_next   = left_link.rec;
            end
        end
    end

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Record payload
    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

### design/min_id_process_queue_core.sv
// ----------------------------------------------------------------------------
// min_id_process_queue_core: bounded min-id priority queue of process records
// A row of cells keeps the records sorted by id, oldest first among equal
// ids; extract takes the head cell and shifts the row down.
// ----------------------------------------------------------------------------
//  channel | dir | ports                      | payload
//  s_      | in  | s_valid s_ready s_data     | mode, process_id, times
//  m_      | out | m_valid m_ready m_data     | status, record, occupancy
//
//  One request is taken per cycle while the result register is free or
//  being drained; its result appears the next cycle.
//  All cells of the row update together: each cell compares its id with
//  the new one and picks from itself, the request or a neighbor.
//  Reset clears the valid flags and the count; no clearing pass is needed.
//  A stalled result holds s_ready low until m_ready takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module min_id_process_queue_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mipq_pkg::mipq_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mipq_pkg::mipq_out_t      m_data
);

    localparam int CAP = mipq_pkg::CAPACITY;
    localparam int CW  = mipq_pkg::CNT_W;

    logic                   s_fire;
    logic                   full;
    logic                   empty;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   m_valid_reg;
    mipq_pkg::mipq_out_t    m_data_reg;
    mipq_pkg::mipq_out_t    m_data_next;
    mipq_pkg::mipq_ctrl_t   ctrl;
    mipq_pkg::mipq_link_t   links [CAP];
    mipq_pkg::mipq_link_t   head_link;
    mipq_pkg::mipq_link_t   tail_link;
    logic [CAP-1:0]         valid_vec;

    // Handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign full  = (count_reg == CW'(CAP));
    assign empty = (count_reg == '0);

    // Control broadcast to the cells
    assign ctrl.insert  = s_fire && (s_data.mode == mipq_pkg::MODE_INSERT) && !full;
    assign ctrl.extract = s_fire && (s_data.mode == mipq_pkg::MODE_EXTRACT) && !empty;
    assign ctrl.rec.id      = s_data.process_id;
    assign ctrl.rec.arrival = s_data.arrival_time;
    assign ctrl.rec.service = s_data.service_time;

    // Ends of the row: a virtual head the new record always sorts after
    assign head_link.valid = 1'b0;
    assign head_link.le    = 1'b1;
    assign head_link.rec   = '0;
    assign tail_link       = '0;

    // Row of cells
    for (genvar i = 0; i < CAP; i++) begin : g_cell
        mipq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .left_link  ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
            .right_link ((i == CAP - 1) ? tail_link : links[(i == CAP - 1) ? i : i + 1]),
            .own_link   (links[i])
        );
        assign valid_vec[i] = links[i].valid;
    end

    // Result and count
    always_comb begin
        count_next  = count_reg;
        m_data_next = '0;
        if (s_data.mode == mipq_pkg::MODE_INSERT) begin
            if (full) begin
                m_data_next.status = mipq_pkg::ST_FULL;
            end else begin
                m_data_next.status = mipq_pkg::ST_INSERTED;
                count_next         = count_reg + CW'(1);
            end
        end else begin
            if (empty) begin
                m_data_next.status = mipq_pkg::ST_EMPTY;
            end else begin
                m_data_next.status      = mipq_pkg::ST_EXTRACTED;
                m_data_next.out_id      = links[0].rec.id;
                m_data_next.out_arrival = links[0].rec.arrival;
                m_data_next.out_service = links[0].rec.service;
                count_next              = count_reg - CW'(1);
            end
        end
        m_data_next.occupancy = 5'(count_next);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // Count never exceeds the row length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAP))
        else $error("queue count above capacity");

    // Valid cells match the count
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("valid cells disagree with count");

    // Head two cells stay in id order
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (links[0].valid && links[1].valid) |-> (links[0].rec.id <= links[1].rec.id))
        else $error("head cells out of order");

    // Accepted insert into a non-full queue grows the count by one
    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_data.mode == mipq_pkg::MODE_INSERT) && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow count");

endmodule

`default_nettype wire
